// ===== design/coverage_column_filter_runs_core_defines.svh =====
// ----------------------------------------------------------------------------
// Coverage column filter assertion macros
// Shared concurrent assertion forms for the coverage column filter checks.
// ----------------------------------------------------------------------------
`ifndef COVERAGE_COLUMN_FILTER_RUNS_CORE_DEFINES_SVH
`define COVERAGE_COLUMN_FILTER_RUNS_CORE_DEFINES_SVH

// check a property on the clock, masked while reset is held
`define CCFR_ASSERT(LBL, CLK, RSTN, PROP) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
    else $error("coverage column filter check failed");

// check a property on the clock, reset included
`define CCFR_ASSERT_RST(LBL, CLK, PROP) \
  LBL: assert property (@(posedge CLK) PROP) \
    else $error("coverage column filter reset check failed");

`endif

// ===== design/ccfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_pkg
// Types and constants shared by the coverage column filter modules.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  localparam int SUM_W      = 24;
  localparam int SQ_W       = 40;
  localparam int CNT_W      = 8;
  localparam int LEN_W      = 11;
  localparam int SAMPLE_W   = 8;
  localparam int THR_W      = 8;
  localparam int MARGIN_W   = 7;
  localparam int MINRUN_W   = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_ADDR_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [SQ_W-1:0]  SQ_MAX  = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // floor(x / 3) for x below 512 as (x * 683) >> 11
  localparam int THIRD_MUL_W = 10;
  localparam logic [THIRD_MUL_W-1:0] THIRD_MUL = 10'd683;
  localparam int THIRD_SHIFT = 11;

  localparam logic [SAMPLE_W-1:0] SAMPLE_COUNT_RST = 8'd111;
  localparam logic [THR_W-1:0]    DEPTH_THR_RST    = 8'd5;
  localparam logic [MARGIN_W-1:0] MARGIN_RST       = 7'd5;
  localparam logic [MINRUN_W-1:0] MIN_RUN_RST      = 10'd20;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SAMPLE_COUNT    = 2'd0,
    REG_DEPTH_THRESHOLD = 2'd1,
    REG_NEAR_ALL_MARGIN = 2'd2,
    REG_MIN_RUN_LENGTH  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_count;
    logic [THR_W-1:0]    depth_threshold;
    logic [MARGIN_W-1:0] near_all_margin;
    logic [MINRUN_W-1:0] min_run_length;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] low;
    logic [CNT_W-1:0] second;
  } col_stats_t;

endpackage

// ===== design/ccfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_front
// Accepts samples, squares and classifies them, and accumulates column stats.
// ----------------------------------------------------------------------------
module ccfr_front #(
  parameter int COVERAGE_BITS = 16,
  parameter int POSITION_BITS = 28
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COVERAGE_BITS-1:0]     in_coverage,
  input  logic [POSITION_BITS-1:0]     in_position,
  input  logic                         in_last_sample,
  input  logic                         in_last_in_region,
  input  logic [ccfr_pkg::THR_W-1:0]   depth_threshold,
  input  logic                         q_full,
  output logic                         q_push,
  output ccfr_pkg::col_stats_t         q_stats,
  output logic [POSITION_BITS-1:0]     q_position,
  output logic                         q_region_end
);
  import ccfr_pkg::*;

  localparam int SQ_IN_W = 2 * COVERAGE_BITS;
  localparam int CMP_W   = (COVERAGE_BITS > THR_W + 1) ? COVERAGE_BITS : THR_W + 1;

  logic                     s1_v_r, s1_v_nxt;
  logic [COVERAGE_BITS-1:0] s1_cov_r;
  logic [SQ_IN_W-1:0]       s1_sq_r;
  logic                     s1_low_r;
  logic                     s1_second_r;
  logic [POSITION_BITS-1:0] s1_pos_r;
  logic                     s1_last_r;
  logic                     s1_region_r;
  col_stats_t               acc_r, acc_nxt;
  col_stats_t               tot;
  logic [SUM_W:0]           sum_ext;
  logic [SQ_W:0]            sq_ext;
  logic                     s1_adv;
  logic                     in_take;
  logic                     cov_low;
  logic                     cov_second;

  assign s1_adv   = s1_v_r && (!s1_last_r || !q_full);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  assign cov_low    = CMP_W'(in_coverage) <= CMP_W'(depth_threshold);
  assign cov_second = !cov_low && (CMP_W'(in_coverage) <= CMP_W'({depth_threshold, 1'b0}));

  always_comb begin
    sum_ext    = {1'b0, acc_r.sum} + (SUM_W + 1)'(s1_cov_r);
    sq_ext     = {1'b0, acc_r.sq} + (SQ_W + 1)'(s1_sq_r);
    tot.sum    = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    tot.sq     = sq_ext[SQ_W] ? SQ_MAX : sq_ext[SQ_W-1:0];
    tot.low    = (s1_low_r && acc_r.low != CNT_MAX) ? acc_r.low + 1'b1 : acc_r.low;
    tot.second = (s1_second_r && acc_r.second != CNT_MAX) ? acc_r.second + 1'b1
                                                          : acc_r.second;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    acc_nxt  = acc_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    if (s1_adv) begin
      acc_nxt = s1_last_r ? '0 : tot;
    end
  end

  assign q_push       = s1_adv && s1_last_r;
  assign q_stats      = tot;
  assign q_position   = s1_pos_r;
  assign q_region_end = s1_region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cov_r    <= in_coverage;
      s1_sq_r     <= SQ_IN_W'(in_coverage) * SQ_IN_W'(in_coverage);
      s1_low_r    <= cov_low;
      s1_second_r <= cov_second;
      s1_pos_r    <= in_position;
      s1_last_r   <= in_last_sample;
      s1_region_r <= in_last_in_region;
    end
  end

endmodule

// ===== design/ccfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_queue
// Short first-in first-out queue of finished columns between front and back.
// ----------------------------------------------------------------------------
module ccfr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/ccfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_back
// Tests each finished column, tracks runs of kept locations and emits results.
// ----------------------------------------------------------------------------
module ccfr_back #(
  parameter int POSITION_BITS = 28
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ccfr_pkg::cfg_t           cfg,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  ccfr_pkg::col_stats_t     q_stats,
  input  logic [POSITION_BITS-1:0] q_position,
  input  logic                     q_region_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_kind,
  output logic [POSITION_BITS-1:0] out_start,
  output logic [POSITION_BITS-1:0] out_end,
  output logic                     out_drop,
  output logic                     out_last
);
  import ccfr_pkg::*;

  localparam int LHS_W   = SQ_W + SAMPLE_W;
  localparam int RHS_W   = 2 * SUM_W;
  localparam int TPROD_W = SAMPLE_W + 1 + THIRD_MUL_W;

  logic                     b1_v_r, b1_v_nxt;
  logic [LHS_W-1:0]         b1_lhs_r;
  logic [RHS_W-1:0]         b1_sq_r;
  logic                     b1_near_r;
  logic                     b1_flat_r;
  logic [POSITION_BITS-1:0] b1_pos_r;
  logic                     b1_region_r;

  logic                     in_run_r, in_run_nxt;
  logic [POSITION_BITS-1:0] run_start_r, run_start_nxt;
  logic [LEN_W-1:0]         run_len_r, run_len_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_kind_r, out_kind_nxt;
  logic [POSITION_BITS-1:0] out_start_r, out_start_nxt;
  logic [POSITION_BITS-1:0] out_end_r, out_end_nxt;
  logic                     out_drop_r, out_drop_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     pend_v_r, pend_v_nxt;
  logic [POSITION_BITS-1:0] pend_start_r, pend_start_nxt;
  logic [POSITION_BITS-1:0] pend_end_r, pend_end_nxt;
  logic                     pend_drop_r, pend_drop_nxt;

  logic [TPROD_W-1:0]       third_prod;
  logic [SAMPLE_W-1:0]      third;
  logic                     near;
  logic                     flat;
  logic                     out_free;
  logic                     consume;
  logic                     b1_load;
  logic                     drop;
  logic                     has_run;
  logic [LEN_W-1:0]         len_inc;
  logic [POSITION_BITS-1:0] start_sel;

  // column tests that need only counts and settings
  assign third_prod = TPROD_W'({cfg.sample_count, 1'b0}) * TPROD_W'(THIRD_MUL);
  assign third      = third_prod[THIRD_SHIFT +: SAMPLE_W];
  assign near = ((SAMPLE_W + 1)'(q_stats.low) + (SAMPLE_W + 1)'(cfg.near_all_margin))
                > (SAMPLE_W + 1)'(cfg.sample_count);
  assign flat = (q_stats.low >= third) &&
                (((SAMPLE_W + 1)'(q_stats.low) + (SAMPLE_W + 1)'(q_stats.second))
                 == (SAMPLE_W + 1)'(cfg.sample_count));

  assign out_free = !out_valid_r || out_ready;
  assign consume  = out_free && !pend_v_r && b1_v_r;
  assign b1_load  = q_valid && (!b1_v_r || consume);
  assign q_pop    = b1_load;

  assign drop      = ({1'b0, b1_lhs_r} > {b1_sq_r, 1'b0}) || b1_near_r || b1_flat_r;
  assign has_run   = drop ? in_run_r : b1_region_r;
  assign len_inc   = !in_run_r ? LEN_W'(1) :
                     (run_len_r == LEN_MAX) ? run_len_r : run_len_r + 1'b1;
  assign start_sel = in_run_r ? run_start_r : b1_pos_r;

  always_comb begin
    b1_v_nxt = b1_v_r;
    if (b1_load) begin
      b1_v_nxt = 1'b1;
    end else if (consume) begin
      b1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    in_run_nxt    = in_run_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    if (consume) begin
      if (drop || b1_region_r) begin
        in_run_nxt  = 1'b0;
        run_len_nxt = '0;
      end else begin
        in_run_nxt    = 1'b1;
        run_start_nxt = start_sel;
        run_len_nxt   = len_inc;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_drop_nxt   = out_drop_r;
    out_last_nxt   = out_last_r;
    pend_v_nxt     = pend_v_r;
    pend_start_nxt = pend_start_r;
    pend_end_nxt   = pend_end_r;
    pend_drop_nxt  = pend_drop_r;
    if (out_free) begin
      out_valid_nxt = pend_v_r || b1_v_r;
      if (pend_v_r) begin
        out_kind_nxt  = 1'b1;
        out_start_nxt = pend_start_r;
        out_end_nxt   = pend_end_r;
        out_drop_nxt  = pend_drop_r;
        out_last_nxt  = 1'b1;
        pend_v_nxt    = 1'b0;
      end else if (b1_v_r) begin
        out_kind_nxt   = 1'b0;
        out_start_nxt  = b1_pos_r;
        out_end_nxt    = b1_pos_r;
        out_drop_nxt   = drop;
        out_last_nxt   = !has_run;
        pend_v_nxt     = has_run;
        pend_start_nxt = drop ? run_start_r : start_sel;
        pend_end_nxt   = drop ? b1_pos_r - 1'b1 : b1_pos_r;
        pend_drop_nxt  = (drop ? run_len_r : len_inc) <= LEN_W'(cfg.min_run_length);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      in_run_r    <= 1'b0;
      run_start_r <= '0;
      run_len_r   <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      b1_v_r      <= b1_v_nxt;
      in_run_r    <= in_run_nxt;
      run_start_r <= run_start_nxt;
      run_len_r   <= run_len_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_load) begin
      b1_lhs_r    <= LHS_W'(cfg.sample_count) * LHS_W'(q_stats.sq);
      b1_sq_r     <= RHS_W'(q_stats.sum) * RHS_W'(q_stats.sum);
      b1_near_r   <= near;
      b1_flat_r   <= flat;
      b1_pos_r    <= q_position;
      b1_region_r <= q_region_end;
    end
    out_kind_r   <= out_kind_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
    out_drop_r   <= out_drop_nxt;
    out_last_r   <= out_last_nxt;
    pend_start_r <= pend_start_nxt;
    pend_end_r   <= pend_end_nxt;
    pend_drop_r  <= pend_drop_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_start = out_start_r;
  assign out_end   = out_end_r;
  assign out_drop  = out_drop_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/coverage_column_filter_runs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_column_filter_runs_core
// Filters locations by per-column coverage statistics and reports kept runs.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one coverage sample per request; tlast closes the location's
//           column, tuser marks the last location of a region.
//   out_* : per closed column a verdict (tuser 0) and, when a run closes, a
//           run report (tuser 1); tlast marks the final result of a column.
//   cfg_* : register writes; the user must write only while no column is in flight, the block does not enforce it.
// Throughput: one sample per cycle while the column queue has room; the output
//   register moves one result a cycle while the receiver is ready, so a column
//   that closes a run holds the output for its verdict and its run report. A
//   four-entry column queue between the accumulator and the test stage absorbs
//   that and short output stalls. A column's verdict follows its last sample
//   through the square register, the column queue, the column test and the output.
// Reset clears the accumulators, run state, queue and output; registers
//   return to their default values. A stalled receiver holds the output
//   and then the queue; the input stalls only once the queue is full.
// ----------------------------------------------------------------------------
module coverage_column_filter_runs_core #(
  parameter int COVERAGE_BITS = 16,
  parameter int POSITION_BITS = 28,
  localparam int IN_W  = ((COVERAGE_BITS + POSITION_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * POSITION_BITS + 1 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,   // coverage, position
  input  logic                            in_tlast,
  input  logic                            in_tuser,   // last_in_region
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,  // start_position, end_position, drop
  output logic                            out_tlast,
  output logic                            out_tuser,  // kind
  input  logic                            cfg_we,
  input  logic [ccfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ccfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ccfr_pkg::*;

  localparam int Q_W   = $bits(col_stats_t) + POSITION_BITS + 1;
  localparam int PAD_W = OUT_W - (2 * POSITION_BITS + 1);

  cfg_t                     cfg_r, cfg_nxt;
  logic                     q_push;
  logic                     q_full;
  logic                     q_pop;
  logic                     q_valid;
  col_stats_t               push_stats;
  logic [POSITION_BITS-1:0] push_pos;
  logic                     push_region;
  logic [Q_W-1:0]           q_wdata;
  logic [Q_W-1:0]           q_rdata;
  col_stats_t               pop_stats;
  logic [POSITION_BITS-1:0] pop_pos;
  logic                     pop_region;
  logic [POSITION_BITS-1:0] res_start;
  logic [POSITION_BITS-1:0] res_end;
  logic                     res_drop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SAMPLE_COUNT:    cfg_nxt.sample_count    = cfg_wdata[SAMPLE_W-1:0];
        REG_DEPTH_THRESHOLD: cfg_nxt.depth_threshold = cfg_wdata[THR_W-1:0];
        REG_NEAR_ALL_MARGIN: cfg_nxt.near_all_margin = cfg_wdata[MARGIN_W-1:0];
        REG_MIN_RUN_LENGTH:  cfg_nxt.min_run_length  = cfg_wdata[MINRUN_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count    <= SAMPLE_COUNT_RST;
      cfg_r.depth_threshold <= DEPTH_THR_RST;
      cfg_r.near_all_margin <= MARGIN_RST;
      cfg_r.min_run_length  <= MIN_RUN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ccfr_front #(
    .COVERAGE_BITS(COVERAGE_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_coverage      (in_tdata[COVERAGE_BITS-1:0]),
    .in_position      (in_tdata[COVERAGE_BITS +: POSITION_BITS]),
    .in_last_sample   (in_tlast),
    .in_last_in_region(in_tuser),
    .depth_threshold  (cfg_r.depth_threshold),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_stats          (push_stats),
    .q_position       (push_pos),
    .q_region_end     (push_region)
  );

  assign q_wdata = {push_region, push_pos, push_stats};

  ccfr_queue #(
    .WIDTH(Q_W),
    .DEPTH(4)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .not_empty(q_valid)
  );

  assign {pop_region, pop_pos, pop_stats} = q_rdata;

  ccfr_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_stats     (pop_stats),
    .q_position  (pop_pos),
    .q_region_end(pop_region),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_tuser),
    .out_start   (res_start),
    .out_end     (res_end),
    .out_drop    (res_drop),
    .out_last    (out_tlast)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_drop, res_end, res_start};

endmodule

// ===== design/coverage_column_filter_runs_core_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_column_filter_runs_core_chk
// Port-level checks on the result channel of the coverage column filter.
// ----------------------------------------------------------------------------
`include "coverage_column_filter_runs_core_defines.svh"

module coverage_column_filter_runs_core_chk #(
  parameter int POSITION_BITS = 28,
  localparam int OUT_W = ((2 * POSITION_BITS + 1 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast,
  input logic             out_tuser
);

  `CCFR_ASSERT_RST(a_reset_clears_out, clk, !rst_n |=> !out_tvalid)
  `CCFR_ASSERT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `CCFR_ASSERT(a_hold_payload, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `CCFR_ASSERT(a_run_report_last, clk, rst_n, out_tvalid && out_tuser |-> out_tlast)
  `CCFR_ASSERT(a_verdict_single, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[POSITION_BITS-1:0] == out_tdata[2*POSITION_BITS-1:POSITION_BITS])

endmodule

bind coverage_column_filter_runs_core coverage_column_filter_runs_core_chk #(
  .POSITION_BITS(POSITION_BITS)
) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);
